@@ rtl/core/assm_pkg.sv @@
`timescale 1ns / 1ps

package assm_pkg;

  localparam int CHANNELS    = 8;
  localparam int SAMPLE_BITS = 24;
  localparam int COEFF_BITS  = 16;
  localparam int CHAN_BITS   = 3;
  localparam int CH_IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = COEFF_BITS;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // alpha (zero-extended) times the widened difference
  localparam int DIFF_BITS = SAMPLE_BITS + 1;
  localparam int PROD_BITS = DIFF_BITS + COEFF_BITS + 1;
  localparam logic signed [PROD_BITS-1:0] ROUND_HALF =
    PROD_BITS'(1) << (COEFF_BITS - 1);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_RISE_COEFF = 1'b0,
    CFG_FALL_COEFF = 1'b1
  } cfg_reg_t;

  typedef logic [CHAN_BITS-1:0]          chan_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [COEFF_BITS-1:0]         coeff_t;

  typedef struct packed {
    chan_t   channel;
    sample_t sample;
    logic    in_range;
  } qentry_t;

  typedef struct packed {
    logic    valid;
    qentry_t entry;
  } qreq_t;

endpackage

@@ rtl/core/assm_if.sv @@
`timescale 1ns / 1ps

interface assm_in_if import assm_pkg::*;;
  logic    valid;
  logic    ready;
  chan_t   channel;
  sample_t in_sample;

  modport source (output valid, output channel, output in_sample, input ready);
  modport sink   (input valid, input channel, input in_sample, output ready);
endinterface

interface assm_out_if import assm_pkg::*;;
  logic    valid;
  logic    ready;
  chan_t   out_channel;
  sample_t out_sample;

  modport source (output valid, output out_channel, output out_sample, input ready);
  modport sink   (input valid, input out_channel, input out_sample, output ready);
endinterface

@@ rtl/core/assm_front.sv @@
`timescale 1ns / 1ps

module assm_front import assm_pkg::*; (
  assm_in_if.sink in_ch,
  input  logic    q_full,
  output qreq_t   push
);

  assign in_ch.ready = !q_full;

  always_comb begin
    push.valid          = in_ch.valid && !q_full;
    push.entry.channel  = in_ch.channel;
    push.entry.sample   = in_ch.in_sample;
    // channels past the stored set pass straight through
    push.entry.in_range = (int'(in_ch.channel) < CHANNELS);
  end

endmodule

@@ rtl/core/assm_queue.sv @@
`timescale 1ns / 1ps

module assm_queue import assm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  qreq_t push,
  output logic  full,
  output qreq_t head,
  input  logic  pop
);

  qentry_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full       = (count_r == QCNT_BITS'(QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.entry = mem_r[rd_ptr_r];

  assign do_push = push.valid && !full;
  assign do_pop  = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

endmodule

@@ rtl/core/assm_back.sv @@
`timescale 1ns / 1ps

module assm_back import assm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  qreq_t                    head,
  output logic                     pop,
  assm_out_if.source               out_ch
);

  coeff_t  rise_r, fall_r;
  sample_t last_r [CHANNELS];

  logic    out_valid_r;
  chan_t   out_chan_r;
  sample_t out_sample_r;

  logic [CH_IDX_BITS-1:0]       idx;
  logic signed [SAMPLE_BITS-1:0] s, prev, res;
  logic signed [DIFF_BITS-1:0]   diff;
  logic [COEFF_BITS-1:0]         alpha;
  logic signed [PROD_BITS-1:0]   prod, rounded, step;

  assign pop = head.valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    idx     = head.entry.channel[CH_IDX_BITS-1:0];
    s       = head.entry.sample;
    prev    = head.entry.in_range ? last_r[idx] : '0;
    alpha   = (s > prev) ? rise_r : fall_r;
    diff    = {prev[SAMPLE_BITS-1], prev} - {s[SAMPLE_BITS-1], s};
    prod    = $signed({1'b0, alpha}) * diff;
    rounded = prod + ROUND_HALF;
    step    = rounded >>> COEFF_BITS;  // floor
    // the sum lands between sample and stored value, so it fits the sample width
    res     = head.entry.in_range ? (s + step[SAMPLE_BITS-1:0]) : s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_r <= '0;
      fall_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_RISE_COEFF: rise_r <= cfg_wdata[COEFF_BITS-1:0];
        CFG_FALL_COEFF: fall_r <= cfg_wdata[COEFF_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_r[i] <= '0;
      end
    end else if (pop && head.entry.in_range) begin
      last_r[idx] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_chan_r   <= head.entry.channel;
      out_sample_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_channel = out_chan_r;
  assign out_ch.out_sample  = out_sample_r;

endmodule

@@ rtl/core/asymmetric_slew_smoother_core.sv @@
`timescale 1ns / 1ps
// Attack/release one-pole smoother, one stored output per channel.
// in_if  : request of channel + signed sample, valid/ready handshake.
// out_if : one result per request, channel echoed, smoothed sample.
// cfg_*  : write-only registers; index 0 rise coefficient, 1 fall coefficient,
//          both Q0.16. Write only while nothing is in flight.
// A request is taken into a two-entry queue; the back end pops it, compares
// against the channel's stored output, picks a coefficient, does one 17x25
// multiply with round-half-up and updates the store in the same cycle.
// Path: a taken request is written into the queue, then popped into the
// output register, from which it is shown on out_if.
// Throughput: one request per cycle while out_if is not stalled; the store
// is updated at the pop, so the same channel can follow back to back.
// Reset (rst_n low, synchronous) clears coefficients, all stored outputs,
// the queue and the output valid flag.
// When out_if stalls the result holds; the queue absorbs up to two more
// requests before in_if.ready drops.
module asymmetric_slew_smoother_core import assm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  assm_in_if.sink                  in_if,
  assm_out_if.source               out_if,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  qreq_t push, head;
  logic  q_full, pop;

  assm_front u_front (
    .in_ch  (in_if),
    .q_full (q_full),
    .push   (push)
  );

  assm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  assm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .pop       (pop),
    .out_ch    (out_if)
  );

endmodule

@@ rtl/core/assm_checker.sv @@
`timescale 1ns / 1ps

module assm_checker import assm_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input chan_t   out_channel,
  input sample_t out_sample
);

  // no result survives reset
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // with the output register empty the queue holds at most one entry,
  // so an offered request is always taken
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !out_valid |-> in_ready)
    else $error("request refused with empty output");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_channel) && $stable(out_sample))
    else $error("result changed while stalled");

endmodule

bind asymmetric_slew_smoother_core assm_checker u_assm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_channel (out_if.out_channel),
  .out_sample  (out_if.out_sample)
);
